// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error("assertion failed");

// consequent holds in the cycle of the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/gsrf_pkg.sv
// ----------------------------------------------------------------------------
// gsrf_pkg
// shared types, constants and helpers of the ratiometric gas sensor filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsrf_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned OFFSET_W   = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [VALUE_W-1:0] MAX16 = '1;

  // moving average window
  localparam int unsigned WINDOW_LEN = 10;
  localparam int unsigned SLOT_W     = $clog2(WINDOW_LEN);
  localparam int unsigned TOTAL_W    = $clog2(WINDOW_LEN * 65535 + 1);
  // reciprocal of the window length, exact over the whole total range
  localparam int unsigned AVG_K      = TOTAL_W + SLOT_W;
  localparam longint unsigned AVG_RECIP =
    ((64'd1 << AVG_K) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int unsigned AVG_PROD_W = TOTAL_W + AVG_K;

  // ratiometric divide: 24-bit dividend, 16 quotient bits after overflow check
  localparam int unsigned QUOT_W     = 2 * SAMPLE_W;
  localparam int unsigned DIV_CNT_W  = $clog2(VALUE_W);

  // calibration
  localparam int unsigned GPROD_W    = VALUE_W + GAIN_W;
  localparam int unsigned ACC_W      = GPROD_W + 2;
  localparam int unsigned CAL_DIV    = 100;
  localparam longint unsigned CAL_LIMIT = CAL_DIV * 65536;
  localparam int unsigned CAL_ACC_W  = $clog2(CAL_LIMIT);
  localparam int unsigned CAL_K      = CAL_ACC_W + $clog2(CAL_DIV);
  localparam longint unsigned CAL_RECIP =
    ((64'd1 << CAL_K) + CAL_DIV - 1) / CAL_DIV;
  localparam int unsigned CAL_PROD_W = CAL_ACC_W + CAL_K;

  // median queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam logic [OFFSET_W-1:0] CAL_OFFSET_RST   = OFFSET_W'(-10860);
  localparam logic [GAIN_W-1:0]   CAL_GAIN_RST     = GAIN_W'(408);
  localparam logic [SAMPLE_W-1:0] REF_SCALE_MV_RST = SAMPLE_W'(2525);
  localparam logic [SAMPLE_W-1:0] BASELINE_MV_RST  = SAMPLE_W'(1230);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_OFFSET   = 8'd0,
    CFG_CAL_GAIN     = 8'd1,
    CFG_REF_SCALE_MV = 8'd2,
    CFG_BASELINE_MV  = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [OFFSET_W-1:0] cal_offset;
    logic [GAIN_W-1:0]   cal_gain;
    logic [SAMPLE_W-1:0] ref_scale_mv;
    logic [SAMPLE_W-1:0] baseline_mv;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] s_med;
    logic [SAMPLE_W-1:0] r_med;
  } med_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] slot;
  } back_stat_t;

  function automatic logic [SAMPLE_W-1:0] mid_of_three(
    input logic [SAMPLE_W-1:0] a,
    input logic [SAMPLE_W-1:0] b,
    input logic [SAMPLE_W-1:0] c
  );
    logic [SAMPLE_W-1:0] m;
    if (a >= b) begin
      if (b >= c) m = b;
      else if (a >= c) m = c;
      else m = a;
    end else begin
      if (a >= c) m = a;
      else if (b >= c) m = c;
      else m = b;
    end
    return m;
  endfunction

endpackage

// File: rtl/gsrf_if.sv
// ----------------------------------------------------------------------------
// gsrf_if
// valid/ready channels of the ratiometric gas sensor filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gsrf_in_if;
  import gsrf_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sense_a;
  logic [SAMPLE_W-1:0] sense_b;
  logic [SAMPLE_W-1:0] sense_c;
  logic [SAMPLE_W-1:0] refer_a;
  logic [SAMPLE_W-1:0] refer_b;
  logic [SAMPLE_W-1:0] refer_c;
  modport source (output valid, sense_a, sense_b, sense_c, refer_a, refer_b, refer_c,
                  input ready);
  modport sink (input valid, sense_a, sense_b, sense_c, refer_a, refer_b, refer_c,
                output ready);
endinterface

interface gsrf_out_if;
  import gsrf_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] concentration;
  logic [VALUE_W-1:0] smoothed_mv;
  logic               saturated;
  modport source (output valid, concentration, smoothed_mv, saturated, input ready);
  modport sink (input valid, concentration, smoothed_mv, saturated, output ready);
endinterface

interface gsrf_cfg_if;
  import gsrf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/gas_sensor_ratiometric_filter.sv
// ----------------------------------------------------------------------------
// gas_sensor_ratiometric_filter
// median, ratiometric scaling, moving average and calibration of gas frames
//
//   channel  dir   payload                                      handshake
//   in_i     in    sense_a..c, refer_a..c (12 bit each)          valid/ready
//   out_o    out   concentration, smoothed_mv (16), saturated     valid/ready
//   cfg_i    in    index (8), data (32)                          valid/ready
//
// a frame passes from queue pop through the back-end states chk, div (the radix-2
// ratiometric divider), ring, avg, clamp, gain, acc, scale and out to the output
// register; a zero or too small reference median skips the divider. the front
// end is combinational and the queue stores median pairs. the back end takes no
// new frame until idle again, and the two-entry queue lets frames arrive while it
// works. a stalled output holds the back end in its last step only. reset clears
// the averaging window and restores register defaults; cfg writes are always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gas_sensor_ratiometric_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  gsrf_in_if.sink    in_i,
  gsrf_out_if.source out_o,
  gsrf_cfg_if.sink   cfg_i
);
  import gsrf_pkg::*;
  `include "assert_macros.svh"

  cfg_t              cfg_q;
  logic              push_valid, push_ready;
  med_t              push_data;
  logic              pop_valid, pop_ready;
  med_t              pop_data;
  logic [QCNT_W-1:0] q_count;
  back_stat_t        back_stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_offset   <= CAL_OFFSET_RST;
      cfg_q.cal_gain     <= CAL_GAIN_RST;
      cfg_q.ref_scale_mv <= REF_SCALE_MV_RST;
      cfg_q.baseline_mv  <= BASELINE_MV_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_CAL_OFFSET:   cfg_q.cal_offset   <= cfg_i.data[OFFSET_W-1:0];
        CFG_CAL_GAIN:     cfg_q.cal_gain     <= cfg_i.data[GAIN_W-1:0];
        CFG_REF_SCALE_MV: cfg_q.ref_scale_mv <= cfg_i.data[SAMPLE_W-1:0];
        CFG_BASELINE_MV:  cfg_q.baseline_mv  <= cfg_i.data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  gsrf_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  gsrf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready),
    .count_o      (q_count)
  );

  gsrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .out_o       (out_o),
    .stat_o      (back_stat)
  );

  // ring pointer stays inside the window
  `ASSERT_ALWAYS(a_slot_range, clk_i, rst_ni, back_stat.slot < SLOT_W'(WINDOW_LEN))
  // a new result only appears right after the back end finishes a frame
  `ASSERT_IMPLIES(a_out_from_done, clk_i, rst_ni, $rose(out_o.valid), $past(back_stat.done))
  // an accepted frame always finds room in the queue
  `ASSERT_IMPLIES(a_push_room, clk_i, rst_ni, in_i.valid && in_i.ready, q_count < QCNT_W'(QUEUE_DEPTH))

endmodule

// File: rtl/gsrf_front.sv
// ----------------------------------------------------------------------------
// gsrf_front
// takes ADC frames and reduces each channel to its median sample
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsrf_front (
  gsrf_in_if.sink          in_i,
  output logic             push_valid_o,
  output gsrf_pkg::med_t   push_data_o,
  input  logic             push_ready_i
);
  import gsrf_pkg::*;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  always_comb begin
    push_data_o.s_med = mid_of_three(in_i.sense_a, in_i.sense_b, in_i.sense_c);
    push_data_o.r_med = mid_of_three(in_i.refer_a, in_i.refer_b, in_i.refer_c);
  end

endmodule

// File: rtl/gsrf_queue.sv
// ----------------------------------------------------------------------------
// gsrf_queue
// short fifo of median pairs between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsrf_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_valid_i,
  input  gsrf_pkg::med_t             push_data_i,
  output logic                       push_ready_o,
  output logic                       pop_valid_o,
  output gsrf_pkg::med_t             pop_data_o,
  input  logic                       pop_ready_i,
  output logic [gsrf_pkg::QCNT_W-1:0] count_o
);
  import gsrf_pkg::*;

  med_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign count_o      = cnt_q;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: rtl/gsrf_back.sv
// ----------------------------------------------------------------------------
// gsrf_back
// ratiometric divide, moving average and linear calibration of one frame
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsrf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gsrf_pkg::cfg_t       cfg_i,
  input  logic                 pop_valid_i,
  input  gsrf_pkg::med_t       pop_data_i,
  output logic                 pop_ready_o,
  gsrf_out_if.source           out_o,
  output gsrf_pkg::back_stat_t stat_o
);
  import gsrf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_DIV,
    ST_RING,
    ST_AVG,
    ST_CLAMP,
    ST_GAIN,
    ST_ACC,
    ST_SCALE,
    ST_OUT
  } state_e;

  state_e                  state_q;
  logic [QUOT_W-1:0]       prod_q;
  logic [SAMPLE_W-1:0]     rmed_q;
  logic [SAMPLE_W-1:0]     rem_q;
  logic [VALUE_W-1:0]      dq_q;
  logic [DIV_CNT_W-1:0]    cnt_q;
  logic                    sat_q;
  logic [VALUE_W-1:0]      store_q [WINDOW_LEN];
  logic [SLOT_W-1:0]       slot_q;
  logic [TOTAL_W-1:0]      total_q;
  logic [AVG_PROD_W-1:0]   avg_prod_q;
  logic [VALUE_W-1:0]      smooth_q;
  logic [VALUE_W-1:0]      diff_q;
  logic [GPROD_W-1:0]      gprod_q;
  logic [ACC_W-1:0]        acc_q;
  logic [CAL_PROD_W-1:0]   cprod_q;
  logic                    neg_q, hi_q;
  logic                    out_valid_q;
  logic [VALUE_W-1:0]      conc_q, smo_q;
  logic                    osat_q;

  logic [SAMPLE_W:0]       trial, trial_sub;
  logic                    fits, ovf, out_free;
  logic [VALUE_W-1:0]      avg_raw;
  logic [TOTAL_W-1:0]      total_d;

  // restoring divide step: remainder shifts in the next dividend bit
  assign trial     = {rem_q, dq_q[VALUE_W-1]};
  assign fits      = (trial >= {1'b0, rmed_q});
  assign trial_sub = trial - {1'b0, rmed_q};
  // quotient would exceed 16 bits (also covers a zero divisor)
  assign ovf       = (SAMPLE_W'(prod_q[QUOT_W-1:VALUE_W]) >= rmed_q);
  assign total_d   = total_q - TOTAL_W'(store_q[slot_q]) + TOTAL_W'(dq_q);
  assign avg_raw   = avg_prod_q[AVG_K +: VALUE_W];
  assign out_free  = !out_valid_q || out_o.ready;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.concentration = conc_q;
  assign out_o.smoothed_mv   = smo_q;
  assign out_o.saturated     = osat_q;
  assign stat_o.done = (state_q == ST_OUT) && out_free;
  assign stat_o.slot = slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prod_q      <= '0;
      rmed_q      <= '0;
      rem_q       <= '0;
      dq_q        <= '0;
      cnt_q       <= '0;
      sat_q       <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) store_q[i] <= '0;
      slot_q      <= '0;
      total_q     <= '0;
      avg_prod_q  <= '0;
      smooth_q    <= '0;
      diff_q      <= '0;
      gprod_q     <= '0;
      acc_q       <= '0;
      cprod_q     <= '0;
      neg_q       <= 1'b0;
      hi_q        <= 1'b0;
      out_valid_q <= 1'b0;
      conc_q      <= '0;
      smo_q       <= '0;
      osat_q      <= 1'b0;
    end else begin
      if ((state_q == ST_OUT) && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            prod_q  <= QUOT_W'(pop_data_i.s_med) * QUOT_W'(cfg_i.ref_scale_mv);
            rmed_q  <= pop_data_i.r_med;
            state_q <= ST_CHK;
          end
        end
        ST_CHK: begin
          cnt_q <= '0;
          rem_q <= SAMPLE_W'(prod_q[QUOT_W-1:VALUE_W]);
          if (ovf) begin
            dq_q    <= MAX16;
            sat_q   <= 1'b1;
            state_q <= ST_RING;
          end else begin
            dq_q    <= prod_q[VALUE_W-1:0];
            sat_q   <= 1'b0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= fits ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
          dq_q  <= {dq_q[VALUE_W-2:0], fits};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_CNT_W'(VALUE_W - 1)) state_q <= ST_RING;
        end
        ST_RING: begin
          total_q         <= total_d;
          store_q[slot_q] <= dq_q;
          slot_q  <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
          state_q <= ST_AVG;
        end
        ST_AVG: begin
          avg_prod_q <= AVG_PROD_W'(total_q) * AVG_PROD_W'(AVG_RECIP);
          state_q    <= ST_CLAMP;
        end
        ST_CLAMP: begin
          if (avg_raw < VALUE_W'(cfg_i.baseline_mv)) begin
            smooth_q <= VALUE_W'(cfg_i.baseline_mv);
            diff_q   <= '0;
          end else begin
            smooth_q <= avg_raw;
            diff_q   <= avg_raw - VALUE_W'(cfg_i.baseline_mv);
          end
          state_q <= ST_GAIN;
        end
        ST_GAIN: begin
          gprod_q <= GPROD_W'(diff_q) * GPROD_W'(cfg_i.cal_gain);
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          acc_q <= ACC_W'(gprod_q)
                 + {{(ACC_W - OFFSET_W){cfg_i.cal_offset[OFFSET_W-1]}}, cfg_i.cal_offset};
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          neg_q   <= acc_q[ACC_W-1];
          hi_q    <= !acc_q[ACC_W-1] && (acc_q >= ACC_W'(CAL_LIMIT));
          cprod_q <= CAL_PROD_W'(acc_q[CAL_ACC_W-1:0]) * CAL_PROD_W'(CAL_RECIP);
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            if (neg_q) conc_q <= '0;
            else if (hi_q) conc_q <= MAX16;
            else conc_q <= cprod_q[CAL_K +: VALUE_W];
            smo_q       <= smooth_q;
            osat_q      <= sat_q || (hi_q && !neg_q);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
